[hdl/lz10_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LZ10 decompressor package
// Shared widths and the command and output-byte types passed between stages.
// ----------------------------------------------------------------------------
package lz10_pkg;

	localparam int WINDOW_BITS = 12;
	localparam int WIN_DEPTH   = 1 << WINDOW_BITS;
	localparam int CNT_W       = 24;
	localparam int LEN_W       = 5;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [LEN_W-1:0] LEN_BIAS  = LEN_W'(3);

	// One decoded token: a literal byte or a back reference.
	typedef struct packed {
		logic                   restart;   // stream restarted since the previous token
		logic                   is_match;
		logic [7:0]             lit_byte;
		logic [WINDOW_BITS-1:0] offset;    // distance minus one
		logic [LEN_W-1:0]       len;       // copy length, 3..18
	} cmd_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       done;
	} obyte_t;

endpackage
`default_nettype wire

[hdl/lz10_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LZ10 token parser
// Takes compressed bytes, tracks flag bits and token phase, keeps the output
// count, and pushes literal and reference commands to the command queue.
// ----------------------------------------------------------------------------
module lz10_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        stream_begin,
	input  wire logic [7:0]                  in_byte,
	input  wire logic [lz10_pkg::CNT_W-1:0]  olen,
	input  wire logic                        q_full,
	output logic                             push,
	output lz10_pkg::cmd_t                   cmd
);
	import lz10_pkg::*;

	typedef enum logic [1:0] {PH_FLAG, PH_TOKEN, PH_SECOND} phase_t;

	phase_t           phase_q, phase_e;
	logic [7:0]       flag_q;
	logic [2:0]       pos_q;
	logic [7:0]       held_q;
	logic [CNT_W-1:0] count_q, count_e, count_n;
	logic             pend_q, pend_e;
	logic             accept;
	logic             room;
	logic [LEN_W-1:0] add;
	logic [CNT_W:0]   sum;

	assign in_stall = q_full;
	assign accept   = in_valid & ~q_full;

	always_comb begin
		phase_e = stream_begin ? PH_FLAG : phase_q;
		count_e = stream_begin ? '0 : count_q;
		pend_e  = stream_begin | pend_q;
		room    = count_e < olen;

		cmd.restart  = pend_e;
		cmd.is_match = (phase_e == PH_SECOND);
		cmd.lit_byte = in_byte;
		cmd.offset   = {held_q[3:0], in_byte};
		cmd.len      = {1'b0, held_q[7:4]} + LEN_BIAS;

		push = 1'b0;
		case (phase_e)
			PH_TOKEN:  push = accept & room & ~flag_q[pos_q];
			PH_SECOND: push = accept;
			default:   push = 1'b0;
		endcase

		add     = cmd.is_match ? cmd.len : LEN_W'(1);
		sum     = {1'b0, count_e} + {{(CNT_W + 1 - LEN_W){1'b0}}, add};
		count_n = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAG;
			flag_q  <= '0;
			pos_q   <= 3'd7;
			held_q  <= '0;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else if (accept) begin
			count_q <= push ? count_n : count_e;
			pend_q  <= push ? 1'b0 : pend_e;
			case (phase_e)
				PH_FLAG: begin
					flag_q  <= in_byte;
					pos_q   <= 3'd7;
					phase_q <= PH_TOKEN;
				end
				PH_TOKEN: begin
					if (room) begin
						if (flag_q[pos_q]) begin
							held_q  <= in_byte;
							phase_q <= PH_SECOND;
						end else if (pos_q == 3'd0) begin
							pos_q   <= 3'd7;
							phase_q <= PH_FLAG;
						end else begin
							pos_q   <= pos_q - 3'd1;
							phase_q <= PH_TOKEN;
						end
					end
				end
				PH_SECOND: begin
					if (pos_q == 3'd0) begin
						pos_q   <= 3'd7;
						phase_q <= PH_FLAG;
					end else begin
						pos_q   <= pos_q - 3'd1;
						phase_q <= PH_TOKEN;
					end
				end
				default: phase_q <= PH_FLAG;
			endcase
		end
	end

endmodule
`default_nettype wire

[hdl/lz10_cmdq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LZ10 command queue
// Two-entry queue that decouples the token parser from the copy engine.
// ----------------------------------------------------------------------------
module lz10_cmdq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire lz10_pkg::cmd_t push_cmd,
	output logic                full,
	input  wire logic           pop,
	output logic                q_valid,
	output lz10_pkg::cmd_t      q_cmd
);
	import lz10_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd   = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

[hdl/lz10_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LZ10 copy engine
// Expands commands into output bytes, one per cycle unless the output stalls,
// through the history window: an issue stage reads the window, a write stage stores and emits.
// ----------------------------------------------------------------------------
module lz10_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cmd_valid,
	input  wire lz10_pkg::cmd_t              cmd,
	output logic                             cmd_pop,
	input  wire logic [lz10_pkg::CNT_W-1:0]  olen,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [7:0]                       out_byte,
	output logic                             run_last,
	output logic                             stream_done
);
	import lz10_pkg::*;

	logic [7:0]             hist_q [WIN_DEPTH];
	logic [7:0]             rdata_q;
	logic [WINDOW_BITS:0]   fill_q;

	// issue stage
	logic                   act_q, lit_q;
	logic [7:0]             litb_q;
	logic [WINDOW_BITS-1:0] dist_q, wp_q;
	logic [LEN_W-1:0]       rem_q;
	logic [CNT_W-1:0]       cnt_q, cnt_inc;

	// write stage
	logic                   v_s1, lit_s1, hit_s1, fillok_s1, last_s1, done_s1;
	logic [7:0]             litb_s1, byp_s1;
	logic [WINDOW_BITS-1:0] wp_s1;

	// output skid
	obyte_t                 ofifo_q [2];
	logic                   ohead_q, otail_q;
	logic [1:0]             ocnt_q;

	logic                   opop, issue, last_a, hit_a, fillok_a, done_a;
	logic [2:0]             occ;
	logic [WINDOW_BITS-1:0] rd_addr;
	logic [WINDOW_BITS:0]   wp1;
	logic [7:0]             byte_b;

	assign out_valid   = (ocnt_q != 2'd0);
	assign out_byte    = ofifo_q[ohead_q].data;
	assign run_last    = ofifo_q[ohead_q].last;
	assign stream_done = ofifo_q[ohead_q].done;

	always_comb begin
		opop     = out_valid & ~out_stall;
		// count the byte in the write stage against the two skid slots
		occ      = {1'b0, ocnt_q} + {2'b0, v_s1} - {2'b0, opop};
		issue    = act_q & (occ < 3'd2);
		last_a   = (rem_q == LEN_W'(1));
		cmd_pop  = cmd_valid & (~act_q | (issue & last_a));
		rd_addr  = wp_q - dist_q - WINDOW_BITS'(1);
		cnt_inc  = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + CNT_W'(1);
		done_a   = (cnt_inc >= olen);
		// forward the byte being written this cycle
		hit_a    = v_s1 & (wp_s1 == rd_addr);
		fillok_a = ({1'b0, rd_addr} < fill_q);
		wp1      = {1'b0, wp_s1} + (WINDOW_BITS + 1)'(1);
		if (lit_s1)         byte_b = litb_s1;
		else if (hit_s1)    byte_b = byp_s1;
		else if (fillok_s1) byte_b = rdata_q;
		else                byte_b = 8'h00;
	end

	always_ff @(posedge clk) begin
		if (v_s1)  hist_q[wp_s1] <= byte_b;
		if (issue) rdata_q <= hist_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			lit_q  <= ~cmd.is_match;
			litb_q <= cmd.lit_byte;
			dist_q <= cmd.offset;
		end
		if (issue) begin
			wp_s1     <= wp_q;
			lit_s1    <= lit_q;
			litb_s1   <= litb_q;
			hit_s1    <= hit_a;
			fillok_s1 <= fillok_a;
			byp_s1    <= byte_b;
			last_s1   <= last_a;
			done_s1   <= done_a;
		end
		if (v_s1) ofifo_q[otail_q] <= '{data: byte_b, last: last_s1, done: done_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			rem_q   <= '0;
			wp_q    <= '0;
			cnt_q   <= '0;
			fill_q  <= '0;
			v_s1    <= 1'b0;
			ohead_q <= 1'b0;
			otail_q <= 1'b0;
			ocnt_q  <= 2'd0;
		end else begin
			v_s1 <= issue;
			if (cmd_pop) begin
				act_q <= 1'b1;
				rem_q <= cmd.is_match ? cmd.len : LEN_W'(1);
			end else if (issue) begin
				act_q <= ~last_a;
				rem_q <= rem_q - LEN_W'(1);
			end
			if (cmd_pop && cmd.restart) begin
				wp_q  <= '0;
				cnt_q <= '0;
			end else if (issue) begin
				wp_q  <= wp_q + WINDOW_BITS'(1);
				cnt_q <= cnt_inc;
			end
			if (v_s1 && (wp1 > fill_q)) fill_q <= wp1;
			if (v_s1) otail_q <= ~otail_q;
			if (opop) ohead_q <= ~ohead_q;
			ocnt_q <= ocnt_q + {1'b0, v_s1} - {1'b0, opop};
		end
	end

	a_skid_room: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, ocnt_q} + {2'b0, v_s1}) <= 3'd2)
		else $error("output skid overfilled");

	a_active_rem: assert property (@(posedge clk) disable iff (!arst_n)
		act_q |-> (rem_q != '0))
		else $error("active command with no bytes left");

	a_bypass_src: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && hit_s1) |-> $past(v_s1))
		else $error("forwarded byte without a prior write");

	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && act_q) |-> ##1 (v_s1 && last_s1))
		else $error("command loaded before previous one finished");

endmodule
`default_nettype wire

[hdl/lz10_stream_decompressor.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LZ10 stream decompressor
// GBA-style LZ77 decoder: parser, command queue and history copy engine.
// ----------------------------------------------------------------------------
// Compressed bytes enter one per cycle while the two-entry command queue has
// room; the copy engine emits one decompressed byte per cycle, unless the
// output stalls, through its single history-window read port, so a literal
// gives one byte and a reference 3 to 18 bytes (its length). Set
// output_length (register 0) while idle. Window entries never written since
// reset read as zero; a fill count tracks them, so there is no clearing pass
// after reset.
module lz10_stream_decompressor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        stream_begin,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             run_last,
	output logic             stream_done,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import lz10_pkg::*;

	localparam logic REG_OUTPUT_LENGTH = 1'b0;

	logic [CNT_W-1:0] olen_q;
	logic             push, q_full, q_valid, cmd_pop, reg_sel;
	cmd_t             push_cmd, q_cmd;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_OUTPUT_LENGTH);
	assign prdata  = reg_sel ? {{(32 - CNT_W){1'b0}}, olen_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			olen_q <= '0;
		end else if (psel && penable && pwrite && reg_sel) begin
			olen_q <= pwdata[CNT_W-1:0];
		end
	end

	lz10_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.stream_begin (stream_begin),
		.in_byte      (in_byte),
		.olen         (olen_q),
		.q_full       (q_full),
		.push         (push),
		.cmd          (push_cmd)
	);

	lz10_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (cmd_pop),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd)
	);

	lz10_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (q_valid),
		.cmd         (q_cmd),
		.cmd_pop     (cmd_pop),
		.olen        (olen_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.run_last    (run_last),
		.stream_done (stream_done)
	);

endmodule
`default_nettype wire

[tb/tb_lz10_stream_decompressor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZ10 stream decompressor testbench
// Feeds compressed byte streams through the valid/stall input port while the
// output side stalls at random, predicts every decompressed byte with a local
// parser and history window, and checks each output byte field by field.
// Covers literals, overlapping and pre-start references, restarts, early stop
// at output_length and zero length, under several APB length settings.
// ----------------------------------------------------------------------------
module tb_lz10_stream_decompressor;
	import lz10_pkg::*;

	localparam logic [2:0] REG_OUTPUT_LENGTH = 3'd0;
	localparam int DRAIN_CYCLES     = 64;
	localparam int WATCHDOG_LIMIT   = 5000;
	localparam int LONG_HOLD_AT     = 60;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int MAX_PRINTED      = 30;

	typedef enum logic [1:0] {WAIT_FLAG, WAIT_TOKEN, WAIT_SECOND} parse_phase_t;

	typedef struct packed {
		logic       restart;
		logic [7:0] data;
	} comp_byte_t;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic        stream_begin = 1'b0;
	logic [7:0]  in_byte      = 8'h00;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [7:0]  out_byte;
	logic        run_last;
	logic        stream_done;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [2:0]  paddr        = 3'd0;
	logic [31:0] pwdata       = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	lz10_stream_decompressor i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.stream_begin (stream_begin),
		.in_byte      (in_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.run_last     (run_last),
		.stream_done  (stream_done),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// Decoder shadow state
	logic [CNT_W-1:0]       cfg_len;
	logic [7:0]             flag_reg;
	logic [2:0]             flag_pos;
	parse_phase_t           parse_phase;
	logic [7:0]             hi_byte;
	logic [7:0]             hist [0:WIN_DEPTH-1];
	logic [WINDOW_BITS-1:0] wr_pos;
	logic [CNT_W-1:0]       out_total;

	comp_byte_t pending_bytes [$];
	obyte_t     expected_bytes [$];

	int in_sent_cnt  = 0;
	int in_acc_cnt   = 0;
	int out_cnt      = 0;
	int cfg_writes   = 0;
	int mismatches   = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int gap_left       = 0;
	int stall_left     = 0;
	int long_hold_left = 0;
	bit long_hold_done = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("MISMATCH %s (output byte %0d): got %0h, expected %0h",
				what, out_cnt, got, want);
	endtask

	function automatic void restart_parse();
		flag_reg    = 8'h00;
		flag_pos    = 3'd7;
		parse_phase = WAIT_FLAG;
		hi_byte     = 8'h00;
		wr_pos      = '0;
		out_total   = '0;
	endfunction

	function automatic void advance_token();
		if (flag_pos == 3'd0) begin
			flag_pos    = 3'd7;
			parse_phase = WAIT_FLAG;
		end else begin
			flag_pos    = flag_pos - 3'd1;
			parse_phase = WAIT_TOKEN;
		end
	endfunction

	function automatic void push_byte(input logic [7:0] b);
		obyte_t r;
		hist[wr_pos] = b;
		wr_pos = wr_pos + 1'b1;
		if (out_total != COUNT_MAX)
			out_total = out_total + 1'b1;
		r.data = b;
		r.last = 1'b0;
		r.done = (out_total >= cfg_len);
		expected_bytes.insert(expected_bytes.size(), r);
	endfunction

	// Work out the output bytes caused by one accepted compressed byte.
	function automatic void decode_byte(input logic restart, input logic [7:0] b);
		int                     n;
		logic [WINDOW_BITS-1:0] dist_m1;
		logic [WINDOW_BITS-1:0] rd;
		logic [LEN_W-1:0]       len;
		obyte_t                 r;
		n = 0;
		if (restart)
			restart_parse();
		case (parse_phase)
			WAIT_FLAG: begin
				flag_reg    = b;
				flag_pos    = 3'd7;
				parse_phase = WAIT_TOKEN;
			end
			WAIT_TOKEN: begin
				// drop token start bytes once the wanted count is reached
				if (out_total < cfg_len) begin
					if (flag_reg[flag_pos]) begin
						hi_byte     = b;
						parse_phase = WAIT_SECOND;
					end else begin
						push_byte(b);
						n = 1;
						advance_token();
					end
				end
			end
			default: begin
				dist_m1 = {hi_byte[3:0], b};
				len     = LEN_W'(hi_byte[7:4]) + LEN_BIAS;
				for (int i = 0; i < int'(len); i++) begin
					rd = wr_pos - dist_m1 - 1'b1;
					push_byte(hist[rd]);
				end
				n = int'(len);
				advance_token();
			end
		endcase
		if (n > 0) begin
			r = expected_bytes.pop_back();
			r.last = 1'b1;
			expected_bytes.insert(expected_bytes.size(), r);
		end
	endfunction

	function automatic void queue_byte(input logic restart, input logic [7:0] d);
		comp_byte_t c;
		c.restart = restart;
		c.data    = d;
		pending_bytes.insert(pending_bytes.size(), c);
	endfunction

	// Mostly well-formed streams with random content, some noise and cut streams.
	task automatic add_streams(input int n_items);
		int         items;
		int         tokens;
		int         made;
		bit         broken;
		logic [7:0] flag;
		logic [7:0] hi;
		logic [7:0] lo;
		items = 0;
		while (items < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				queue_byte(1'($urandom_range(0, 1)), 8'($urandom));
				continue;
			end
			broken = ($urandom_range(0, 9) == 0);
			tokens = $urandom_range(1, 40);
			made   = 0;
			flag   = 8'($urandom);
			queue_byte(1'b1, flag);
			items++;
			for (int k = 0; k < tokens && made < int'(cfg_len); k++) begin
				if (k > 0 && k % 8 == 0) begin
					flag = 8'($urandom);
					queue_byte(1'b0, flag);
					items++;
				end
				if (flag[7 - (k % 8)]) begin
					hi = 8'($urandom);
					if ($urandom_range(0, 3) != 0) begin
						hi[3:0] = 4'h0;
						lo = 8'($urandom_range(0, 15));
					end else begin
						lo = 8'($urandom);
					end
					queue_byte(1'b0, hi);
					items++;
					// cut the stream inside a reference
					if (broken && k == tokens - 1)
						break;
					queue_byte(1'b0, lo);
					items++;
					made += int'(hi[7:4]) + 3;
				end else begin
					queue_byte(1'b0, 8'($urandom));
					items++;
					made++;
				end
			end
			if (made >= int'(cfg_len) && $urandom_range(0, 1) == 1)
				queue_byte(1'b0, 8'($urandom));
		end
	endtask

	task automatic apb_cycle(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= REG_OUTPUT_LENGTH;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_output_length(input logic [CNT_W-1:0] v);
		logic [31:0] rb;
		apb_cycle(1'b1, {8'h00, v}, rb);
		cfg_len = v;
		cfg_writes++;
		apb_cycle(1'b0, 32'h0, rb);
		if (rb[CNT_W-1:0] !== v)
			report_mismatch("output_length readback", rb, {8'h00, v});
	endtask

	// Hold until every request is in, every byte is out and the engine is quiet.
	task automatic wait_drained();
		@(posedge clk);
		while (pending_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Input driver
	always @(negedge clk) begin : sender
		comp_byte_t nxt;
		if (in_valid && in_acc_cnt != in_sent_cnt) begin
			// hold the stalled request
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (pending_bytes.size() == 0) begin
			in_valid <= 1'b0;
		end else if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			gap_left = $urandom_range(0, 6);
			in_valid <= 1'b0;
		end else begin
			nxt = pending_bytes.pop_front();
			stream_begin <= nxt.restart;
			in_byte      <= nxt.data;
			in_valid     <= 1'b1;
			in_sent_cnt++;
		end
	end

	// Output stall driver
	always @(negedge clk) begin : receiver
		if (!long_hold_done && in_acc_cnt >= LONG_HOLD_AT) begin
			long_hold_done = 1'b1;
			long_hold_left = LONG_HOLD_CYCLES;
		end
		if (long_hold_left > 0) begin
			long_hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
			stall_left = $urandom_range(0, 6);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Predict on accepted input, check accepted output
	always @(posedge clk) begin : scoreboard
		obyte_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				decode_byte(stream_begin, in_byte);
				in_acc_cnt++;
			end
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch("output with none expected", {24'h0, out_byte}, 32'h0);
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.data)
						report_mismatch("out_byte", {24'h0, out_byte}, {24'h0, want.data});
					if (run_last !== want.last)
						report_mismatch("run_last", 32'(run_last), 32'(want.last));
					if (stream_done !== want.done)
						report_mismatch("stream_done", 32'(stream_done), 32'(want.done));
				end
				out_cnt++;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(psel && penable && pready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles, %0d bytes still expected",
					quiet_cycles, expected_bytes.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < WIN_DEPTH; i++)
			hist[i] = 8'h00;
		restart_parse();
		cfg_len = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// First byte after reset acts as flag byte without a restart
		set_output_length(COUNT_MAX);
		send_idle_pct = 15;
		recv_idle_pct = 15;
		queue_byte(1'b0, 8'h3C);
		queue_byte(1'b0, 8'h00);
		queue_byte(1'b0, 8'hFF);
		queue_byte(1'b0, 8'hF0);  // distance 1, length 18: overlapping copy
		queue_byte(1'b0, 8'h00);
		queue_byte(1'b0, 8'h0F);  // distance 4096 reaches before the stream
		queue_byte(1'b0, 8'hFF);
		queue_byte(1'b0, 8'h20);
		queue_byte(1'b0, 8'h01);
		queue_byte(1'b0, 8'h50);
		queue_byte(1'b0, 8'hFF);
		queue_byte(1'b0, 8'hA5);
		queue_byte(1'b0, 8'h5A);
		// restart keeps the window, so these read stale history
		queue_byte(1'b1, 8'hC0);
		queue_byte(1'b0, 8'h0F);
		queue_byte(1'b0, 8'hFF);
		queue_byte(1'b0, 8'hF1);
		queue_byte(1'b0, 8'h23);
		wait_drained();

		// Zero length: only the flag byte is used, the token bytes are dropped
		set_output_length('0);
		queue_byte(1'b1, 8'h80);
		queue_byte(1'b0, 8'h12);
		queue_byte(1'b0, 8'h34);
		wait_drained();

		// Stop inside a match: the match is emitted whole, later tokens dropped
		set_output_length(CNT_W'(2));
		queue_byte(1'b1, 8'h40);
		queue_byte(1'b0, 8'h11);
		queue_byte(1'b0, 8'h30);
		queue_byte(1'b0, 8'h01);
		queue_byte(1'b0, 8'h77);
		queue_byte(1'b0, 8'h88);
		wait_drained();

		set_output_length(COUNT_MAX);
		send_idle_pct = 10;
		recv_idle_pct = 10;
		add_streams(110);
		wait_drained();

		set_output_length(CNT_W'($urandom_range(10, 60)));
		send_idle_pct = 5;
		recv_idle_pct = 20;
		add_streams(100);
		wait_drained();

		set_output_length(CNT_W'(1));
		send_idle_pct = 20;
		recv_idle_pct = 5;
		add_streams(40);
		wait_drained();

		// Last part runs at full rate on both sides
		set_output_length(CNT_W'($urandom_range(200, 2000)));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_streams(90);
		wait_drained();

		$display("Run: %0d compressed bytes accepted, %0d output bytes checked, %0d length settings",
			in_acc_cnt, out_cnt, cfg_writes);
		$display("Covered literals, overlapping and stale references, restarts, early stop, zero length");
		if (mismatches == 0 && expected_bytes.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/lz10_pkg.sv
hdl/lz10_front.sv
hdl/lz10_cmdq.sv
hdl/lz10_back.sv
hdl/lz10_stream_decompressor.sv
tb/tb_lz10_stream_decompressor.sv
